>>> sv/qdc_pkg.sv
`default_nettype none

package qdc_pkg;

  // Widths fixed by the word format
  localparam int unsigned OutW         = 32;
  localparam int unsigned SpdW         = 5;
  localparam int unsigned RemW         = 5;
  localparam int unsigned CountWidthDef = 32;

  localparam logic [SpdW-1:0] SpdReset = 5'd4;
  localparam logic [SpdW-1:0] SpdMin   = 5'd1;
  localparam logic [SpdW-1:0] SpdMax   = 5'd16;

  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_TAKE    = 2'd1,
    OP_DISCARD = 2'd2,
    OP_PRIME   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_UP   = 2'd1,
    STEP_DOWN = 2'd2
  } step_e;

  // Previous AB pair in [3:2], current in [1:0]; double transitions count as none
  function automatic step_e step_decode(input logic [3:0] hist);
    step_e s;
    unique case (hist)
      4'h1, 4'h7, 4'h8, 4'hE: s = STEP_DOWN;
      4'h2, 4'h4, 4'hB, 4'hD: s = STEP_UP;
      default:                s = STEP_NONE;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

>>> sv/qdc_divider.sv
`default_nettype none

module qdc_divider #(
  parameter int unsigned DividendW = 33
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [DividendW-1:0]       dividend_i,
  input  wire logic [qdc_pkg::SpdW-1:0]   divisor_i,
  output logic                            busy_o,
  output logic [DividendW-1:0]            quotient_o,
  output logic [qdc_pkg::SpdW-2:0]        remainder_o
);
  import qdc_pkg::*;

  localparam int unsigned CntW = $clog2(DividendW + 1);
  localparam logic [CntW-1:0] CntLoad = CntW'(DividendW);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  logic                 busy_q, busy_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [DividendW-1:0] work_q, work_d;
  logic [SpdW-2:0]      rem_q, rem_d;
  logic [SpdW-1:0]      trial;
  logic [SpdW-1:0]      diff;
  logic                 fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem_q, work_q[DividendW-1]};
  assign fits  = (trial >= divisor_i);
  assign diff  = trial - divisor_i;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    work_d = work_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntLoad;
      work_d = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      work_d = {work_q[DividendW-2:0], fits};
      rem_d  = fits ? diff[SpdW-2:0] : trial[SpdW-2:0];
      cnt_d  = cnt_q - CntOne;
      if (cnt_q == CntOne) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
  end

  assign busy_o      = busy_q;
  assign quotient_o  = work_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

>>> sv/quadrature_detent_counter.sv
// Channel  Dir  Handshake                 Word
// in       in   in_valid_i / in_ready_o   opcode_i, line_a_i, line_b_i
// out      out  out_valid_o / out_ready_i detents_o, pending_steps_o
// cfg      in   cfg_valid_i / cfg_ready_o cfg_steps_per_detent_i
//
// Sample, discard and prime words complete on acceptance; the result register
// loads at the accepting edge and the next word may enter in the next cycle.
// A take word runs a radix-2 restoring divide, one quotient bit per cycle
// over COUNT_WIDTH + 1 bits, so the input side is held until the divide
// finishes and the result register is free to take its result.
// A stalled result holds in the output register; input is taken only while
// that register is empty or being drained. Reset clears all counts and
// history and loads steps_per_detent with 4. The cfg port is always ready.
`default_nettype none

module quadrature_detent_counter #(
  parameter int unsigned COUNT_WIDTH = qdc_pkg::CountWidthDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // Input words
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [1:0]                 opcode_i,
  input  wire logic                       line_a_i,
  input  wire logic                       line_b_i,
  // Result words
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic signed [qdc_pkg::OutW-1:0] detents_o,
  output logic signed [qdc_pkg::OutW-1:0] pending_steps_o,
  // Configuration
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [qdc_pkg::SpdW-1:0]   cfg_steps_per_detent_i
);
  import qdc_pkg::*;

  localparam int unsigned SumW = COUNT_WIDTH + 1;

  localparam logic signed [COUNT_WIDTH-1:0] CntMax  = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  localparam logic signed [COUNT_WIDTH-1:0] CntMin  = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
  localparam logic signed [COUNT_WIDTH-1:0] CntOne  = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
  localparam logic signed [RemW-1:0]        RemLow  = {1'b1, {(RemW-1){1'b0}}};

  // Sequencer codes
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic                            state_q, state_d;
  logic [3:0]                      hist_q, hist_d;
  logic signed [COUNT_WIDTH-1:0]   count_q, count_d;
  logic signed [RemW-1:0]          rem_q, rem_d;
  logic [SpdW-1:0]                 spd_q;
  logic                            neg_q;
  logic                            out_valid_q, out_valid_d;
  logic signed [OutW-1:0]          detents_q, detents_d;
  logic signed [OutW-1:0]          pending_q, pending_d;

  logic                            out_free;
  logic                            accept;
  logic                            div_start;
  logic                            div_busy;
  logic                            finish;
  logic [3:0]                      sample_hist;
  step_e                           step;
  logic signed [COUNT_WIDTH-1:0]   count_step;
  logic signed [SumW-1:0]          sum;
  logic [SumW-1:0]                 sum_mag;
  logic [SpdW-1:0]                 divisor;
  logic [SumW-1:0]                 quot_mag;
  logic [SpdW-2:0]                 rem_mag;
  logic signed [SumW-1:0]          quot;
  logic signed [COUNT_WIDTH-1:0]   quot_sat;
  logic signed [RemW-1:0]          rem_fix;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign div_start  = accept && (opcode_i == OP_TAKE);
  assign finish     = (state_q == ST_DIV) && !div_busy && out_free;

  // Sample path: shift the new AB pair into the history and apply the step
  assign sample_hist = {hist_q[1:0], line_a_i, line_b_i};
  assign step        = step_decode(sample_hist);

  always_comb begin
    count_step = count_q;
    unique case (step)
      STEP_UP:   if (count_q != CntMax) count_step = count_q + CntOne;
      STEP_DOWN: if (count_q != CntMin) count_step = count_q - CntOne;
      default:   count_step = count_q;
    endcase
  end

  // Take path: divide the magnitude of remainder + pending steps
  assign sum     = SumW'(count_q) + SumW'(rem_q);
  assign sum_mag = sum[SumW-1] ? SumW'(-sum) : SumW'(sum);

  // A zero divisor acts as one, anything above sixteen as sixteen
  always_comb begin
    if (spd_q < SpdMin) begin
      divisor = SpdMin;
    end else if (spd_q > SpdMax) begin
      divisor = SpdMax;
    end else begin
      divisor = spd_q;
    end
  end

  qdc_divider #(
    .DividendW (SumW)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (sum_mag),
    .divisor_i   (divisor),
    .busy_o      (div_busy),
    .quotient_o  (quot_mag),
    .remainder_o (rem_mag)
  );

  // Restore signs: truncation toward zero gives remainder the sign of the sum
  assign quot    = neg_q ? -signed'(quot_mag) : signed'(quot_mag);
  assign rem_fix = neg_q ? -signed'({1'b0, rem_mag}) : signed'({1'b0, rem_mag});

  // Clamp the quotient when its top two bits disagree
  always_comb begin
    if (quot[SumW-1] == quot[COUNT_WIDTH-1]) begin
      quot_sat = quot[COUNT_WIDTH-1:0];
    end else if (quot[SumW-1]) begin
      quot_sat = CntMin;
    end else begin
      quot_sat = CntMax;
    end
  end

  always_comb begin
    state_d     = state_q;
    hist_d      = hist_q;
    count_d     = count_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q;
    detents_d   = detents_q;
    pending_d   = pending_q;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (accept) begin
      unique case (opcode_i)
        OP_SAMPLE: begin
          hist_d  = sample_hist;
          count_d = count_step;
        end
        OP_TAKE: begin
          state_d = ST_DIV;
        end
        OP_DISCARD: begin
          count_d = '0;
          rem_d   = '0;
        end
        OP_PRIME: begin
          hist_d = {2'b00, line_a_i, line_b_i};
        end
        default: begin
          hist_d = hist_q;
        end
      endcase
      if (opcode_i != OP_TAKE) begin
        out_valid_d = 1'b1;
        detents_d   = '0;
        pending_d   = OutW'(count_d);
      end
    end

    if (finish) begin
      state_d     = ST_IDLE;
      count_d     = '0;
      rem_d       = rem_fix;
      out_valid_d = 1'b1;
      detents_d   = OutW'(quot_sat);
      pending_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hist_q      <= '0;
      count_q     <= '0;
      rem_q       <= '0;
      spd_q       <= SpdReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hist_q      <= hist_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        spd_q <= cfg_steps_per_detent_i;
      end
    end
  end

  // Hold the sign of the sum for the whole divide
  always_ff @(posedge clk_i) begin
    detents_q <= detents_d;
    pending_q <= pending_d;
    if (div_start) begin
      neg_q <= sum[SumW-1];
    end
  end

  assign cfg_ready_o     = 1'b1;
  assign out_valid_o     = out_valid_q;
  assign detents_o       = detents_q;
  assign pending_steps_o = pending_q;

  // Input side must be closed while the divider runs
  a_busy_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> !in_ready_o)
    else $error("input ready while divide in progress");

  // Remainder magnitude stays below sixteen
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q != RemLow)
    else $error("detent remainder out of range");

  // A finished divide always presents a result next cycle
  a_finish_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> (out_valid_o && (state_q == ST_IDLE) && (pending_steps_o == '0)))
    else $error("take result not presented");

  // A take leaves the idle state and starts the divider together
  a_take_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> (div_busy && (state_q == ST_DIV)))
    else $error("take did not start divide");

endmodule

`default_nettype wire
